// ===== rtl/sptma_pkg.sv =====
// shared codes and sizing constants for the sparse polynomial merge-add block
// used by every module of the block; depends on nothing
package sptma_pkg;

  // field widths and store depth of the default build
  localparam int MAX_TERMS_DEF = 32;
  localparam int EXP_BITS_DEF  = 8;
  localparam int COEF_BITS_DEF = 16;

  // request codes carried on the mode field
  localparam int MODE_BITS = 2;
  localparam logic [MODE_BITS-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_RUN    = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_NONE   = 2'd3;

  // depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 4;

  // handshake of one side of a channel between two modules
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== rtl/sptma_front.sv =====
// front part: takes requests, drops unused codes, holds one classified request
// depends on sptma_pkg
module sptma_front #(
  parameter int EXP_BITS  = sptma_pkg::EXP_BITS_DEF,
  parameter int COEF_BITS = sptma_pkg::COEF_BITS_DEF,
  parameter int CMD_W     = sptma_pkg::MODE_BITS + COEF_BITS + 2 * EXP_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sptma_pkg::MODE_BITS-1:0]   in_mode,
  input  logic signed [COEF_BITS-1:0]       in_coef,
  input  logic [EXP_BITS-1:0]               in_exp_x,
  input  logic [EXP_BITS-1:0]               in_exp_y,
  output sptma_pkg::hs_t                    push_hs_o,
  input  logic                              push_ready,
  output logic [CMD_W-1:0]                  push_cmd
);

  logic             hold_v_r, hold_v_nxt;
  logic [CMD_W-1:0] hold_cmd_r, hold_cmd_nxt;
  logic             push;
  logic             take;

  assign push     = hold_v_r && push_ready;
  assign in_ready = !hold_v_r || push_ready;
  // unused mode code is swallowed here and never reaches the queue
  assign take     = in_valid && in_ready && (in_mode != sptma_pkg::MODE_NONE);

  always_comb begin
    hold_v_nxt   = hold_v_r;
    hold_cmd_nxt = hold_cmd_r;
    if (take) begin
      hold_v_nxt   = 1'b1;
      hold_cmd_nxt = {in_mode, in_coef, in_exp_x, in_exp_y};
    end else if (push) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
    hold_cmd_r <= hold_cmd_nxt;
  end

  assign push_hs_o.valid = hold_v_r;
  assign push_hs_o.ready = push_ready;
  assign push_cmd        = hold_cmd_r;

endmodule

// ===== rtl/sptma_queue.sv =====
// short request queue between the front and the back
// depends on sptma_pkg for its depth
module sptma_queue #(
  parameter int W = 34
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  logic [W-1:0]   wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output logic [W-1:0]   rd_data
);

  localparam int DEPTH = sptma_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          wr, rd;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/sptma_back.sv =====
// back part: term stores, merge walk and output register
// depends on sptma_pkg for request codes
module sptma_back #(
  parameter int MAX_TERMS = sptma_pkg::MAX_TERMS_DEF,
  parameter int EXP_BITS  = sptma_pkg::EXP_BITS_DEF,
  parameter int COEF_BITS = sptma_pkg::COEF_BITS_DEF,
  parameter int CMD_W     = sptma_pkg::MODE_BITS + COEF_BITS + 2 * EXP_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  logic [CMD_W-1:0]            cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COEF_BITS:0]   out_sum_coef,
  output logic [EXP_BITS-1:0]         out_sum_exp_x,
  output logic [EXP_BITS-1:0]         out_sum_exp_y,
  output logic                        out_last,
  output logic                        out_empty_res,
  output logic                        out_overflow
);

  localparam int TW = COEF_BITS + 2 * EXP_BITS;
  localparam int KW = 2 * EXP_BITS;
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state_r, state_nxt;
  logic [TW-1:0] mem_a [MAX_TERMS];
  logic [TW-1:0] mem_b [MAX_TERMS];
  logic [TW-1:0] rd_a_r, rd_b_r;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic [AW-1:0] addr_a, addr_b;
  logic          drop_r, drop_nxt;

  logic                           pop, step, out_free;
  logic [sptma_pkg::MODE_BITS-1:0] cmd_mode;
  logic [TW-1:0]                  cmd_term;
  logic                           wr_a, wr_b;
  logic                           a_has, b_has, done;
  logic [KW-1:0]                  key_a, key_b;
  logic signed [COEF_BITS:0]      ca_ext, cb_ext;

  logic                           ov_r, ov_nxt;
  logic signed [COEF_BITS:0]      oc_r, oc_nxt;
  logic [EXP_BITS-1:0]            ox_r, ox_nxt, oy_r, oy_nxt;
  logic                           ol_r, ol_nxt, oe_r, oe_nxt, oo_r, oo_nxt;

  assign cmd_mode  = cmd[CMD_W-1 -: sptma_pkg::MODE_BITS];
  assign cmd_term  = cmd[TW-1:0];
  assign cmd_ready = (state_r == ST_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign out_free  = !ov_r || out_ready;
  assign step      = (state_r == ST_RUN) && out_free;

  assign wr_a = pop && (cmd_mode == sptma_pkg::MODE_LOAD_A) && (cnt_a_r != CW'(MAX_TERMS));
  assign wr_b = pop && (cmd_mode == sptma_pkg::MODE_LOAD_B) && (cnt_b_r != CW'(MAX_TERMS));

  assign a_has  = (ia_r < cnt_a_r);
  assign b_has  = (ib_r < cnt_b_r);
  assign key_a  = rd_a_r[KW-1:0];
  assign key_b  = rd_b_r[KW-1:0];
  assign ca_ext = (COEF_BITS + 1)'($signed(rd_a_r[TW-1 -: COEF_BITS]));
  assign cb_ext = (COEF_BITS + 1)'($signed(rd_b_r[TW-1 -: COEF_BITS]));

  always_comb begin
    state_nxt = state_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    drop_nxt  = drop_r;
    ia_nxt    = ia_r;
    ib_nxt    = ib_r;
    done      = 1'b0;
    ov_nxt    = ov_r && !out_ready;
    oc_nxt    = oc_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    ol_nxt    = ol_r;
    oe_nxt    = oe_r;
    oo_nxt    = oo_r;
    if (pop) begin
      case (cmd_mode)
        sptma_pkg::MODE_LOAD_A: begin
          if (wr_a) cnt_a_nxt = cnt_a_r + 1'b1;
          else      drop_nxt  = 1'b1;
        end
        sptma_pkg::MODE_LOAD_B: begin
          if (wr_b) cnt_b_nxt = cnt_b_r + 1'b1;
          else      drop_nxt  = 1'b1;
        end
        sptma_pkg::MODE_RUN: begin
          state_nxt = ST_RUN;
        end
        default: begin
        end
      endcase
    end
    if (step) begin
      ov_nxt = 1'b1;
      oe_nxt = 1'b0;
      oo_nxt = drop_r;
      if (a_has && b_has) begin
        if (key_a > key_b) begin
          oc_nxt = ca_ext;
          {ox_nxt, oy_nxt} = key_a;
          ia_nxt = ia_r + 1'b1;
        end else if (key_b > key_a) begin
          oc_nxt = cb_ext;
          {ox_nxt, oy_nxt} = key_b;
          ib_nxt = ib_r + 1'b1;
        end else begin
          // equal exponent pairs combine, a zero sum still goes out
          oc_nxt = ca_ext + cb_ext;
          {ox_nxt, oy_nxt} = key_a;
          ia_nxt = ia_r + 1'b1;
          ib_nxt = ib_r + 1'b1;
        end
      end else if (a_has) begin
        oc_nxt = ca_ext;
        {ox_nxt, oy_nxt} = key_a;
        ia_nxt = ia_r + 1'b1;
      end else if (b_has) begin
        oc_nxt = cb_ext;
        {ox_nxt, oy_nxt} = key_b;
        ib_nxt = ib_r + 1'b1;
      end else begin
        // both stores empty: a single zero term flagged as empty
        oc_nxt = '0;
        ox_nxt = '0;
        oy_nxt = '0;
        oe_nxt = 1'b1;
      end
      // walk ends once both advanced positions reach their counts
      done   = (ia_nxt >= cnt_a_r) && (ib_nxt >= cnt_b_r);
      ol_nxt = done;
      if (done) begin
        state_nxt = ST_IDLE;
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
        drop_nxt  = 1'b0;
        ia_nxt    = '0;
        ib_nxt    = '0;
      end
    end
  end

  // read ahead at the walk position of the next cycle
  assign addr_a = (ia_nxt < CW'(MAX_TERMS)) ? ia_nxt[AW-1:0] : '0;
  assign addr_b = (ib_nxt < CW'(MAX_TERMS)) ? ib_nxt[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[AW-1:0]] <= cmd_term;
    end
    if (wr_b) begin
      mem_b[cnt_b_r[AW-1:0]] <= cmd_term;
    end
    rd_a_r <= mem_a[addr_a];
    rd_b_r <= mem_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      drop_r  <= 1'b0;
      ia_r    <= '0;
      ib_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      drop_r  <= drop_nxt;
      ia_r    <= ia_nxt;
      ib_r    <= ib_nxt;
      ov_r    <= ov_nxt;
    end
    oc_r <= oc_nxt;
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
    ol_r <= ol_nxt;
    oe_r <= oe_nxt;
    oo_r <= oo_nxt;
  end

  assign out_valid     = ov_r;
  assign out_sum_coef  = oc_r;
  assign out_sum_exp_x = ox_r;
  assign out_sum_exp_y = oy_r;
  assign out_last      = ol_r;
  assign out_empty_res = oe_r;
  assign out_overflow  = oo_r;

  a_cnt_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CW'(MAX_TERMS))
    else $error("store A count beyond depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ia_r <= cnt_a_r) && (ib_r <= cnt_b_r))
    else $error("walk position past store count");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done) |=> (cnt_a_r == '0) && (cnt_b_r == '0) && !drop_r && (state_r == ST_IDLE))
    else $error("stores not emptied after last result");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oe_r) |-> (ol_r && (oc_r == '0)))
    else $error("empty result not a lone zero term");

endmodule

// ===== rtl/sparse_poly_term_merge_add_top.sv =====
// Sparse two-variable polynomial adder by sorted merge.
// Input channel (in_valid/in_ready): mode 0 appends a term to store A, mode 1
// to store B, mode 2 runs the merge-add, mode 3 is discarded. Load requests
// produce no result; a run produces one result per merged term on the output
// channel (out_valid/out_ready), with out_last on its final term, out_overflow
// on every term when a load into a full store was dropped since the last run,
// and a single zero term with out_empty_res when both stores were empty.
// Load requests are taken one per cycle while the queue has room. A run
// goes through the front register and the queue to the back, which
// registers its first term on the output; the rest follow one per cycle
// while the receiver is ready, paced by the single read port on each store,
// read one entry ahead of the walk. Requests behind a run wait in the front
// register and a four-entry queue, five in all, and are taken while not full.
// When the receiver stalls, the output register holds its term and the walk
// pauses; the queue and front keep taking requests until they fill.
// Reset (rst_n, synchronous, active low) empties both stores, clears the
// overflow flag, the queue and the output register.
// Depends on sptma_pkg, sptma_front, sptma_queue, sptma_back.
module sparse_poly_term_merge_add_top #(
  parameter int MAX_TERMS = sptma_pkg::MAX_TERMS_DEF,
  parameter int EXP_BITS  = sptma_pkg::EXP_BITS_DEF,
  parameter int COEF_BITS = sptma_pkg::COEF_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sptma_pkg::MODE_BITS-1:0]  in_mode,
  input  logic signed [COEF_BITS-1:0]      in_coef,
  input  logic [EXP_BITS-1:0]              in_exp_x,
  input  logic [EXP_BITS-1:0]              in_exp_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [COEF_BITS:0]        out_sum_coef,
  output logic [EXP_BITS-1:0]              out_sum_exp_x,
  output logic [EXP_BITS-1:0]              out_sum_exp_y,
  output logic                             out_last,
  output logic                             out_empty_res,
  output logic                             out_overflow
);

  localparam int CMD_W = sptma_pkg::MODE_BITS + COEF_BITS + 2 * EXP_BITS;

  sptma_pkg::hs_t   push_hs;
  logic             push_ready;
  logic [CMD_W-1:0] push_cmd;
  logic             q_valid, q_ready;
  logic [CMD_W-1:0] q_cmd;

  sptma_front #(
    .EXP_BITS  (EXP_BITS),
    .COEF_BITS (COEF_BITS),
    .CMD_W     (CMD_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_coef    (in_coef),
    .in_exp_x   (in_exp_x),
    .in_exp_y   (in_exp_y),
    .push_hs_o  (push_hs),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sptma_queue #(
    .W (CMD_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_hs.valid),
    .wr_ready (push_ready),
    .wr_data  (push_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  sptma_back #(
    .MAX_TERMS (MAX_TERMS),
    .EXP_BITS  (EXP_BITS),
    .COEF_BITS (COEF_BITS),
    .CMD_W     (CMD_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sum_coef  (out_sum_coef),
    .out_sum_exp_x (out_sum_exp_x),
    .out_sum_exp_y (out_sum_exp_y),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_overflow  (out_overflow)
  );

endmodule

// ===== sim/sptma_merge_checker.sv =====
// checker for the sparse polynomial merge-add block: watches the request and
// result channels, predicts the terms of every merge run and compares them
// depends on sptma_pkg
module sptma_merge_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [sptma_pkg::MODE_BITS-1:0]       in_mode,
  input  logic [sptma_pkg::COEF_BITS_DEF-1:0]   in_coef,
  input  logic [sptma_pkg::EXP_BITS_DEF-1:0]    in_exp_x,
  input  logic [sptma_pkg::EXP_BITS_DEF-1:0]    in_exp_y,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [sptma_pkg::COEF_BITS_DEF:0]     out_sum_coef,
  input  logic [sptma_pkg::EXP_BITS_DEF-1:0]    out_sum_exp_x,
  input  logic [sptma_pkg::EXP_BITS_DEF-1:0]    out_sum_exp_y,
  input  logic                                  out_last,
  input  logic                                  out_empty_res,
  input  logic                                  out_overflow,
  output int                                    mismatch_count,
  output int                                    pending_terms,
  output int                                    runs_seen,
  output int                                    terms_checked
);
  localparam int COEF_W = sptma_pkg::COEF_BITS_DEF;
  localparam int EXP_W  = sptma_pkg::EXP_BITS_DEF;
  localparam int DEPTH  = sptma_pkg::MAX_TERMS_DEF;

  typedef struct {
    logic [COEF_W-1:0] coef;
    logic [EXP_W-1:0]  ex;
    logic [EXP_W-1:0]  ey;
  } stored_term_t;

  typedef struct {
    logic [COEF_W:0]   coef;
    logic [EXP_W-1:0]  ex;
    logic [EXP_W-1:0]  ey;
    logic              is_last;
    logic              is_empty;
    logic              ovf;
  } sum_term_t;

  stored_term_t store_a [DEPTH];
  stored_term_t store_b [DEPTH];
  int           fill_a = 0;
  int           fill_b = 0;
  logic         dropped = 1'b0;
  sum_term_t    expected_terms [$];
  int           mismatches = 0;
  int           runs = 0;
  int           checked = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch on %s: got %0h, want %0h (term %0d)", what, got, want, checked);
  endtask

  // walk both stores the way the block does, one term per step
  task automatic predict_merge();
    int        i;
    int        j;
    logic      take_a;
    logic      take_b;
    sum_term_t r;
    i = 0;
    j = 0;
    r.ovf = dropped;
    r.is_empty = 1'b0;
    if (fill_a == 0 && fill_b == 0) begin
      r.coef = '0;
      r.ex = '0;
      r.ey = '0;
      r.is_last = 1'b1;
      r.is_empty = 1'b1;
      expected_terms.push_back(r);
    end
    while (i < fill_a || j < fill_b) begin
      take_a = (j >= fill_b) || (i < fill_a &&
               {store_a[i].ex, store_a[i].ey} > {store_b[j].ex, store_b[j].ey});
      take_b = !take_a && ((i >= fill_a) ||
               {store_b[j].ex, store_b[j].ey} > {store_a[i].ex, store_a[i].ey});
      if (take_a) begin
        r.coef = {store_a[i].coef[COEF_W-1], store_a[i].coef};
        r.ex = store_a[i].ex;
        r.ey = store_a[i].ey;
        i++;
      end else if (take_b) begin
        r.coef = {store_b[j].coef[COEF_W-1], store_b[j].coef};
        r.ex = store_b[j].ex;
        r.ey = store_b[j].ey;
        j++;
      end else begin
        // equal exponent pair: full-width sum, zero kept
        r.coef = {store_a[i].coef[COEF_W-1], store_a[i].coef} +
                 {store_b[j].coef[COEF_W-1], store_b[j].coef};
        r.ex = store_a[i].ex;
        r.ey = store_a[i].ey;
        i++;
        j++;
      end
      r.is_last = (i >= fill_a && j >= fill_b);
      expected_terms.push_back(r);
    end
    fill_a = 0;
    fill_b = 0;
    dropped = 1'b0;
    runs++;
  endtask

  task automatic check_term();
    sum_term_t want;
    if (expected_terms.size() == 0) begin
      report_mismatch("result term with none expected", 32'(out_sum_coef), 0);
      return;
    end
    want = expected_terms.pop_front();
    if (out_sum_coef !== want.coef)
      report_mismatch("sum_coef", 32'(out_sum_coef), 32'(want.coef));
    if (out_sum_exp_x !== want.ex)
      report_mismatch("sum_exp_x", 32'(out_sum_exp_x), 32'(want.ex));
    if (out_sum_exp_y !== want.ey)
      report_mismatch("sum_exp_y", 32'(out_sum_exp_y), 32'(want.ey));
    if (out_last !== want.is_last)
      report_mismatch("last", 32'(out_last), 32'(want.is_last));
    if (out_empty_res !== want.is_empty)
      report_mismatch("empty_res", 32'(out_empty_res), 32'(want.is_empty));
    if (out_overflow !== want.ovf)
      report_mismatch("overflow", 32'(out_overflow), 32'(want.ovf));
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_a = 0;
      fill_b = 0;
      dropped = 1'b0;
      expected_terms.delete();
    end else begin
      if (in_valid && in_ready) begin
        case (in_mode)
          sptma_pkg::MODE_LOAD_A: begin
            if (fill_a >= DEPTH) begin
              dropped = 1'b1;
            end else begin
              store_a[fill_a] = '{in_coef, in_exp_x, in_exp_y};
              fill_a++;
            end
          end
          sptma_pkg::MODE_LOAD_B: begin
            if (fill_b >= DEPTH) begin
              dropped = 1'b1;
            end else begin
              store_b[fill_b] = '{in_coef, in_exp_x, in_exp_y};
              fill_b++;
            end
          end
          sptma_pkg::MODE_RUN: predict_merge();
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_term();
    end
    mismatch_count <= mismatches;
    pending_terms <= expected_terms.size();
    runs_seen <= runs;
    terms_checked <= checked;
  end

endmodule

// ===== sim/testbench.sv =====
// top of the merge-add testbench: clock, reset, request and receiver stimulus
// and the verdict; depends on sptma_pkg, sptma_merge_checker and the block
module testbench;

  localparam int COEF_W      = sptma_pkg::COEF_BITS_DEF;
  localparam int EXP_W       = sptma_pkg::EXP_BITS_DEF;
  localparam int MODE_W      = sptma_pkg::MODE_BITS;
  localparam int DEPTH       = sptma_pkg::MAX_TERMS_DEF;
  localparam int KEY_W       = 2 * EXP_W;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 100;
  localparam int QUIET_AFTER = 90;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode;
  logic [COEF_W-1:0]    in_coef;
  logic [EXP_W-1:0]     in_exp_x;
  logic [EXP_W-1:0]     in_exp_y;
  logic                 out_valid;
  logic                 out_ready;
  logic [COEF_W:0]      out_sum_coef;
  logic [EXP_W-1:0]     out_sum_exp_x;
  logic [EXP_W-1:0]     out_sum_exp_y;
  logic                 out_last;
  logic                 out_empty_res;
  logic                 out_overflow;

  int mismatch_count;
  int pending_terms;
  int runs_seen;
  int terms_checked;
  int cycle_count = 0;
  int requests_sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  sparse_poly_term_merge_add_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_coef(in_coef),
    .in_exp_x(in_exp_x), .in_exp_y(in_exp_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_sum_coef(out_sum_coef),
    .out_sum_exp_x(out_sum_exp_x), .out_sum_exp_y(out_sum_exp_y), .out_last(out_last),
    .out_empty_res(out_empty_res), .out_overflow(out_overflow)
  );

  sptma_merge_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_coef(in_coef),
    .in_exp_x(in_exp_x), .in_exp_y(in_exp_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_sum_coef(out_sum_coef),
    .out_sum_exp_x(out_sum_exp_x), .out_sum_exp_y(out_sum_exp_y), .out_last(out_last),
    .out_empty_res(out_empty_res), .out_overflow(out_overflow),
    .mismatch_count(mismatch_count), .pending_terms(pending_terms),
    .runs_seen(runs_seen), .terms_checked(terms_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // receiver: short stall bursts, one long hold-off on request, none at the end
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(COEF_W-1){1'b1}}};
      1: return {1'b1, {(COEF_W-1){1'b0}}};
      2: return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // offer one request and hold it until taken, then maybe go idle a while
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [COEF_W-1:0] coef,
                              input logic [EXP_W-1:0] ex, input logic [EXP_W-1:0] ey);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_coef <= coef;
    in_exp_x <= ex;
    in_exp_y <= ey;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (mode != sptma_pkg::MODE_NONE) requests_sent++;
    // the last stretch of the run goes without idle cycles
    if (requests_sent >= QUIET_AFTER) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // load two polynomials with interleaved requests, then run the merge
  task automatic send_poly_pair(input int na, input int nb, input bit sorted,
                                input bit narrow, input bit share);
    logic [KEY_W-1:0] keys_a [$];
    logic [KEY_W-1:0] keys_b [$];
    logic [KEY_W-1:0] k;
    int               ia;
    int               ib;
    for (ia = 0; ia < na; ia++) begin
      if (narrow) k = {EXP_W'($urandom_range(0, 3)), EXP_W'($urandom_range(0, 3))};
      else k = KEY_W'($urandom);
      keys_a.push_back(k);
    end
    for (ib = 0; ib < nb; ib++) begin
      // shared pairs give equal-exponent sums
      if (share && na > 0 && $urandom_range(0, 1) == 1) k = keys_a[$urandom_range(0, na - 1)];
      else if (narrow) k = {EXP_W'($urandom_range(0, 3)), EXP_W'($urandom_range(0, 3))};
      else k = KEY_W'($urandom);
      keys_b.push_back(k);
    end
    if (sorted) begin
      keys_a.rsort();
      keys_b.rsort();
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        send_request(sptma_pkg::MODE_LOAD_A, random_coef(),
                     keys_a[ia][KEY_W-1:EXP_W], keys_a[ia][EXP_W-1:0]);
        ia++;
      end else begin
        send_request(sptma_pkg::MODE_LOAD_B, random_coef(),
                     keys_b[ib][KEY_W-1:EXP_W], keys_b[ib][EXP_W-1:0]);
        ib++;
      end
    end
    send_request(sptma_pkg::MODE_RUN, random_coef(), EXP_W'($urandom), EXP_W'($urandom));
  endtask

  initial begin
    int seq;
    int pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= sptma_pkg::MODE_NONE;
    in_coef <= '0;
    in_exp_x <= '0;
    in_exp_y <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // run over empty stores, ignored fields at extremes
    send_request(sptma_pkg::MODE_RUN, 16'h8000, 8'hff, 8'h00);
    // extreme sums, a zero sum, greater pairs on each side
    send_request(sptma_pkg::MODE_LOAD_A, 16'h7fff, 8'hff, 8'hff);
    send_request(sptma_pkg::MODE_LOAD_B, 16'h7fff, 8'hff, 8'hff);
    send_request(sptma_pkg::MODE_LOAD_A, 16'd100, 8'd10, 8'd2);
    send_request(sptma_pkg::MODE_LOAD_B, 16'hffff, 8'd10, 8'd1);
    send_request(sptma_pkg::MODE_LOAD_A, 16'd5, 8'd3, 8'd7);
    send_request(sptma_pkg::MODE_LOAD_B, -16'sd5, 8'd3, 8'd7);
    send_request(sptma_pkg::MODE_LOAD_A, 16'h8000, 8'd0, 8'd0);
    send_request(sptma_pkg::MODE_LOAD_B, 16'h8000, 8'd0, 8'd0);
    send_request(sptma_pkg::MODE_NONE, 16'h7fff, 8'hff, 8'hff);
    send_request(sptma_pkg::MODE_RUN, 16'h7fff, 8'h00, 8'hff);
    // store A out of order
    send_request(sptma_pkg::MODE_LOAD_A, 16'd1, 8'd1, 8'd0);
    send_request(sptma_pkg::MODE_LOAD_A, 16'd2, 8'd5, 8'd5);
    send_request(sptma_pkg::MODE_LOAD_B, 16'd3, 8'd3, 8'd3);
    send_request(sptma_pkg::MODE_RUN, 16'h0000, 8'h00, 8'h00);
    // only B, then only A with a zero coefficient
    send_request(sptma_pkg::MODE_LOAD_B, 16'd7, 8'd200, 8'd9);
    send_request(sptma_pkg::MODE_LOAD_B, -16'sd7, 8'd200, 8'd8);
    send_request(sptma_pkg::MODE_RUN, 16'h1234, 8'h55, 8'haa);
    send_request(sptma_pkg::MODE_LOAD_A, 16'd0, 8'd0, 8'd255);
    send_request(sptma_pkg::MODE_RUN, 16'hffff, 8'haa, 8'h55);
    send_request(sptma_pkg::MODE_RUN, 16'h0001, 8'h01, 8'h01);

    seq = 0;
    while (requests_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (seq == 0) begin
        // receiver holds off while runs pile up behind a merge
        hold_req = 1'b1;
        send_poly_pair(5, 5, 1'b1, 1'b0, 1'b1);
        repeat (6) begin
          send_request(sptma_pkg::MODE_RUN, random_coef(), EXP_W'($urandom),
                       EXP_W'($urandom));
        end
      end else if (seq == 2) begin
        // both stores overflow, the run emits the most terms
        send_poly_pair(DEPTH + 1, DEPTH + 1, 1'b1, 1'b0, 1'b0);
      end else if (pick == 0) begin
        send_request(sptma_pkg::MODE_NONE, random_coef(), EXP_W'($urandom),
                     EXP_W'($urandom));
      end else if (pick <= 2) begin
        send_poly_pair($urandom_range(0, 5), $urandom_range(0, 5), 1'b0,
                       1'($urandom_range(0, 1)), 1'b1);
      end else if (pick == 3) begin
        send_poly_pair($urandom_range(8, 16), $urandom_range(8, 16), 1'b1, 1'b0, 1'b1);
      end else begin
        send_poly_pair($urandom_range(0, 6), $urandom_range(0, 6), 1'b1,
                       1'($urandom_range(0, 1)), 1'b1);
      end
      seq++;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_terms != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d requests: %0d merge runs, %0d result terms checked",
             requests_sent, runs_seen, terms_checked);
    $display("covered field extremes, zero and empty sums, unsorted and full stores, "
             , "unused mode and a long output stall");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sptma_pkg.sv
rtl/sptma_front.sv
rtl/sptma_queue.sv
rtl/sptma_back.sv
rtl/sparse_poly_term_merge_add_top.sv
sim/sptma_merge_checker.sv
sim/testbench.sv
